>>> hw/rtl/emad_pkg.sv
// Shared types and constants for the emulated address map decoder.
// Holds transaction structs, configuration struct, region and access codes.
// No dependencies.
package emad_pkg;

    // access kinds
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_EXEC   = 2'd3;

    // highest function code that counts as user space
    localparam logic [2:0] USER_FC_MAX = 3'd2;

    // region codes
    localparam logic [3:0] REGION_FAULT   = 4'd0;
    localparam logic [3:0] REGION_ALLOC   = 4'd1;
    localparam logic [3:0] REGION_MAIN    = 4'd2;
    localparam logic [3:0] REGION_ALT     = 4'd3;
    localparam logic [3:0] REGION_SOUND   = 4'd4;
    localparam logic [3:0] REGION_ROM     = 4'd5;
    localparam logic [3:0] REGION_USERLOW = 4'd6;
    localparam logic [3:0] REGION_LOWMEM  = 4'd7;
    localparam logic [3:0] REGION_VIA     = 4'd8;
    localparam logic [3:0] REGION_CALLOUT = 4'd9;

    // address map constants
    localparam logic [31:0] HIGH_SPACE_FLOOR  = 32'hFFFF_0000;
    localparam logic [31:0] ADDR24_MASK       = 32'h00FF_FFFF;
    localparam logic [15:0] ROM_PAGE          = 16'h0040;
    localparam logic [7:0]  VIA_PAGE          = 8'hEF;
    localparam logic [31:0] PROT_LOW_LIMIT    = 32'd1024;
    localparam logic [31:0] USER_LOW_LIMIT    = 32'd3072;
    localparam logic [21:0] WRITE_GUARD_BLOCK = 22'd7;

    // register indexes
    localparam logic [2:0] IDX_ALLOC_START  = 3'd0;
    localparam logic [2:0] IDX_ALLOC_LIMIT  = 3'd1;
    localparam logic [2:0] IDX_SCREEN_BYTES = 3'd2;
    localparam logic [2:0] IDX_LOW_MEM      = 3'd3;
    localparam logic [2:0] IDX_MAIN_BASE    = 3'd4;
    localparam logic [2:0] IDX_ALT_BASE     = 3'd5;
    localparam logic [2:0] IDX_SOUND_BASE   = 3'd6;
    localparam logic [2:0] IDX_PAGES        = 3'd7;

    localparam int PADDR_W = 5;

    // reset values
    localparam logic [23:0] RST_SCREEN_BYTES = 24'd21888;
    localparam logic [23:0] RST_MAIN_BASE    = 24'd108288;
    localparam logic [23:0] RST_ALT_BASE     = 24'd75520;
    localparam logic [23:0] RST_SOUND_BASE   = 24'd130304;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [15:0] byte_count;
        logic [2:0]  function_code;
        logic        alt_page_enabled;
        logic        screen_unlocked;
        logic        showing_main_page;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  region;
        logic [31:0] offset;
        logic        refresh_screen;
    } t_out_item;

    // live configuration plus precomputed window ends (25 bits, never wrap)
    typedef struct packed {
        logic [31:0] alloc_start;
        logic [31:0] alloc_limit;
        logic [23:0] screen_bytes;
        logic [24:0] low_mem_bytes;
        logic [23:0] main_base;
        logic [23:0] alt_base;
        logic [23:0] sound_base;
        logic [1:0]  pages_present;
        logic [24:0] main_end;
        logic [24:0] alt_end;
        logic [24:0] sound_end;
    } t_cfg;

endpackage

>>> hw/rtl/emad_cfg_regs.sv
// APB-style configuration register file for the address map decoder.
// Also forms the screen and sound window end addresses from the live registers.
// Depends on emad_pkg.
module emad_cfg_regs #(
    parameter int SOUND_SPAN = 740
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [emad_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output emad_pkg::t_cfg               o_cfg
);
    import emad_pkg::*;

    localparam logic [24:0] SPAN = 25'(SOUND_SPAN);

    logic        w_wr;
    logic [2:0]  w_idx;
    logic [31:0] r_alloc_start;
    logic [31:0] r_alloc_limit;
    logic [23:0] r_screen_bytes;
    logic [24:0] r_low_mem;
    logic [23:0] r_main_base;
    logic [23:0] r_alt_base;
    logic [23:0] r_sound_base;
    logic [1:0]  r_pages;
    logic [24:0] w_main_end;
    logic [24:0] w_alt_end;
    logic [24:0] w_sound_end;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_start  <= '0;
            r_alloc_limit  <= '0;
            r_screen_bytes <= RST_SCREEN_BYTES;
            r_low_mem      <= '0;
            r_main_base    <= RST_MAIN_BASE;
            r_alt_base     <= RST_ALT_BASE;
            r_sound_base   <= RST_SOUND_BASE;
            r_pages        <= '0;
        end else if (w_wr) begin
            case (w_idx)
                IDX_ALLOC_START:  r_alloc_start  <= pwdata;
                IDX_ALLOC_LIMIT:  r_alloc_limit  <= pwdata;
                IDX_SCREEN_BYTES: r_screen_bytes <= pwdata[23:0];
                IDX_LOW_MEM:      r_low_mem      <= pwdata[24:0];
                IDX_MAIN_BASE:    r_main_base    <= pwdata[23:0];
                IDX_ALT_BASE:     r_alt_base     <= pwdata[23:0];
                IDX_SOUND_BASE:   r_sound_base   <= pwdata[23:0];
                IDX_PAGES:        r_pages        <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // window ends follow the base registers in the same cycle
    assign w_main_end  = {1'b0, r_main_base} + {1'b0, r_screen_bytes};
    assign w_alt_end   = {1'b0, r_alt_base} + {1'b0, r_screen_bytes};
    assign w_sound_end = {1'b0, r_sound_base} + SPAN;

    always_comb begin
        case (w_idx)
            IDX_ALLOC_START:  prdata = r_alloc_start;
            IDX_ALLOC_LIMIT:  prdata = r_alloc_limit;
            IDX_SCREEN_BYTES: prdata = {8'd0, r_screen_bytes};
            IDX_LOW_MEM:      prdata = {7'd0, r_low_mem};
            IDX_MAIN_BASE:    prdata = {8'd0, r_main_base};
            IDX_ALT_BASE:     prdata = {8'd0, r_alt_base};
            IDX_SOUND_BASE:   prdata = {8'd0, r_sound_base};
            IDX_PAGES:        prdata = {30'd0, r_pages};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.alloc_start   = r_alloc_start;
    assign o_cfg.alloc_limit   = r_alloc_limit;
    assign o_cfg.screen_bytes  = r_screen_bytes;
    assign o_cfg.low_mem_bytes = r_low_mem;
    assign o_cfg.main_base     = r_main_base;
    assign o_cfg.alt_base      = r_alt_base;
    assign o_cfg.sound_base    = r_sound_base;
    assign o_cfg.pages_present = r_pages;
    assign o_cfg.main_end      = w_main_end;
    assign o_cfg.alt_end       = w_alt_end;
    assign o_cfg.sound_end     = w_sound_end;

endmodule

>>> hw/rtl/emad_decode.sv
// Combinational address decode for one access against the live configuration.
// Priority chain of range compares, then offset selection.
// Depends on emad_pkg.
module emad_decode (
    input  emad_pkg::t_in_item  i_item,
    input  emad_pkg::t_cfg      i_cfg,
    output emad_pkg::t_out_item o_result
);
    import emad_pkg::*;

    logic [31:0] w_a;
    logic [32:0] w_a_end;
    logic [32:0] w_a33;
    logic        w_exec;
    logic        w_user;
    logic        w_alloc_hit;
    logic        w_main_hit;
    logic        w_alt_hit;
    logic        w_sound_hit;
    logic        w_rom_hit;
    logic        w_userlow_hit;
    logic        w_low_hit;
    logic        w_low_ok;
    logic        w_via_hit;

    assign w_a     = (i_item.address < HIGH_SPACE_FLOOR) ? (i_item.address & ADDR24_MASK)
                                                         : i_item.address;
    assign w_a33   = {1'b0, w_a};
    assign w_a_end = w_a33 + {17'd0, i_item.byte_count};
    assign w_exec  = (i_item.action == ACT_EXEC);
    assign w_user  = (i_item.function_code <= USER_FC_MAX);

    assign w_alloc_hit = (w_a >= i_cfg.alloc_start) && (w_a < i_cfg.alloc_limit);

    assign w_main_hit = (w_a33 < {8'd0, i_cfg.main_end})
                     && (w_a_end <= {8'd0, i_cfg.main_end})
                     && (w_a >= {8'd0, i_cfg.main_base});

    assign w_alt_hit = i_item.alt_page_enabled
                    && (w_a33 < {8'd0, i_cfg.alt_end})
                    && (w_a_end <= {8'd0, i_cfg.alt_end})
                    && (w_a >= {8'd0, i_cfg.alt_base});

    assign w_sound_hit = (w_a >= {8'd0, i_cfg.sound_base})
                      && (w_a < {7'd0, i_cfg.sound_end});

    assign w_rom_hit = (w_a[31:16] == ROM_PAGE);

    // bit 10 clear keeps the lower 1K of each 2K block
    assign w_userlow_hit = (w_a < USER_LOW_LIMIT) && !w_a[10] && w_user && !w_exec;

    assign w_low_hit = (w_a < {7'd0, i_cfg.low_mem_bytes});

    // guards pass and the whole access must fit below the segment size
    assign w_low_ok = !((w_a < PROT_LOW_LIMIT) && (w_user || w_exec))
                   && !((w_a[31:10] == WRITE_GUARD_BLOCK) && (i_item.action == ACT_WRITE))
                   && (w_a_end <= {8'd0, i_cfg.low_mem_bytes});

    assign w_via_hit = (w_a[23:16] == VIA_PAGE);

    always_comb begin
        o_result.region         = REGION_CALLOUT;
        o_result.offset         = w_a;
        o_result.refresh_screen = 1'b0;
        if (w_alloc_hit) begin
            o_result.region = REGION_ALLOC;
        end else if (w_main_hit) begin
            if (w_exec || !i_cfg.pages_present[0]) begin
                o_result.region = REGION_FAULT;
            end else begin
                o_result.region         = REGION_MAIN;
                o_result.offset         = w_a - {8'd0, i_cfg.main_base};
                o_result.refresh_screen = i_item.screen_unlocked
                                       && (i_item.action == ACT_UPDATE)
                                       && i_item.showing_main_page;
            end
        end else if (w_alt_hit) begin
            if (w_exec || !i_cfg.pages_present[1]) begin
                o_result.region = REGION_FAULT;
            end else begin
                o_result.region = REGION_ALT;
                o_result.offset = w_a - {8'd0, i_cfg.alt_base};
            end
        end else if (w_sound_hit) begin
            o_result.region = REGION_SOUND;
            o_result.offset = w_a - {8'd0, i_cfg.sound_base};
        end else if (w_rom_hit) begin
            o_result.region = REGION_ROM;
        end else if (w_userlow_hit) begin
            o_result.region = REGION_USERLOW;
        end else if (w_low_hit) begin
            o_result.region = w_low_ok ? REGION_LOWMEM : REGION_FAULT;
        end else if (w_via_hit) begin
            o_result.region = REGION_VIA;
        end
    end

endmodule

>>> hw/rtl/emulated_address_map_decoder_top.sv
// Top level of the emulated address map decoder: input register, decode,
// result register, and the APB configuration port.
// Depends on emad_pkg, emad_cfg_regs and emad_decode.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  -----------------------
//  access    in         i_in_valid / o_in_ready       i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_ready     o_out_data (t_out_item)
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A result turns valid once its access has passed the input register and then the
// result register; one access per cycle is sustained while the result side is not
// stalled, set by the single decode stage between the two registers. Reset is
// synchronous, active low; it clears the valid bits and loads the register
// defaults. A stalled result holds in the result register while the input
// register still takes one more transaction.
module emulated_address_map_decoder_top #(
    parameter int SOUND_SPAN = 740
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  emad_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output emad_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [emad_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import emad_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_out_free;
    t_cfg      w_cfg;
    t_out_item w_dec;

    emad_cfg_regs #(
        .SOUND_SPAN(SOUND_SPAN)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    emad_decode u_decode (
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_result(w_dec)
    );

    // result register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // take a new transaction whenever the input register can move on
    assign o_in_ready = !r_in_valid || w_out_free;

    // input register: hold the access while the result side is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register: advance the decoded transaction when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_out_free) begin
            r_out <= w_dec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // refresh only ever comes with a main screen hit
    a_refresh_main : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.refresh_screen |-> o_out_data.region == REGION_MAIN)
        else $error("refresh flagged outside main screen");

    // sound offsets stay inside the window
    a_sound_offset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.region == REGION_SOUND |->
            o_out_data.offset < 32'(SOUND_SPAN))
        else $error("sound offset beyond window");

    // a held input transaction with a stalled result must not be lost
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |=> r_in_valid && $stable(r_in))
        else $error("input register dropped a stalled transaction");

    // a valid input stage always lands in the result stage when it is free
    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_out_free |=> r_out_valid)
        else $error("decoded transaction not advanced");

    // region codes stay in the defined set
    a_region_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.region <= REGION_CALLOUT)
        else $error("undefined region code");

endmodule
